[rtl/core/dracc_pkg.sv]
// Package for the DMA region access checker: sizes, operation codes,
// register layout constants, the region record and the region decode function.
// No dependencies.
package dracc_pkg;

  localparam int unsigned RegisterWords = 8192;
  localparam int unsigned RegionCount   = 16;
  localparam int unsigned AddressBits   = 42;

  localparam int unsigned RegionsMax  = 16;
  localparam int unsigned PageShift   = 12;
  localparam int unsigned OffsetW     = 13;
  localparam int unsigned DataW       = 32;
  localparam int unsigned FieldW      = 30;
  localparam int unsigned MemAw       = $clog2(RegisterWords);
  localparam int unsigned PageW       = AddressBits - PageShift;
  localparam int unsigned CmpW        = (PageW > FieldW + 1) ? PageW : FieldW + 1;

  localparam int unsigned SizeWord    = 'h00 / 4;
  localparam int unsigned BaseWord    = 'h40 / 4;
  localparam int unsigned Size3Word   = 'h80 / 4;
  localparam int unsigned ShadowWords = Size3Word + RegionsMax;
  localparam int unsigned ShadowAw    = $clog2(ShadowWords);

  localparam int unsigned NarrowBaseW = 24;
  localparam int unsigned V1SizeW     = 19;
  localparam int unsigned V2SizeW     = 24;
  localparam int unsigned FlagLowW    = 12;

  localparam logic [1:0] Version1 = 2'd1;
  localparam logic [1:0] Version2 = 2'd2;
  localparam logic [1:0] Version3 = 2'd3;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpRead  = 2'd1,
    OpXlate = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef struct packed {
    logic               en;
    logic [OffsetW-1:0] offset;
    logic [DataW-1:0]   data;
  } reg_wr_t;

  typedef struct packed {
    logic [FieldW-1:0] base;
    logic [FieldW-1:0] size;
    logic [DataW-1:0]  flags;
  } region_t;

  function automatic region_t decode_region(input logic [1:0]       version,
                                            input logic [DataW-1:0] w0,
                                            input logic [DataW-1:0] wb,
                                            input logic [DataW-1:0] ws);
    region_t r;
    unique case (version)
      Version3: begin
        r.base  = wb[FieldW-1:0];
        r.size  = ws[FieldW-1:0];
        r.flags = w0;
      end
      Version2: begin
        r.base  = FieldW'(wb[NarrowBaseW-1:0]);
        r.size  = FieldW'(w0[V2SizeW-1:0]);
        r.flags = DataW'(w0[FlagLowW-1:0]);
      end
      default: begin
        r.base  = FieldW'(wb[NarrowBaseW-1:0]);
        r.size  = FieldW'(w0[V1SizeW-1:0]);
        r.flags = {w0[DataW-1], {(DataW-1-FlagLowW){1'b0}}, w0[FlagLowW-1:0]};
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/dracc_regions.sv]
// Region table: shadow copy of the region layout words, per-region decode
// lanes with change detection, and the parallel page range check.
// Depends on dracc_pkg.
module dracc_regions import dracc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  reg_wr_t               wr_i,
  input  logic [1:0]            version_i,
  input  logic [PageW-1:0]      page_i,
  output logic [RegionsMax-1:0] changed_o,
  output logic                  hit_o
);

  logic [DataW-1:0]       shadow_q [ShadowWords];
  logic [DataW-1:0]       shadow_d [ShadowWords];
  region_t                region_q [RegionCount];
  region_t                dec      [RegionCount];
  logic [RegionCount-1:0] changed;
  logic [RegionCount-1:0] hit;

  always_comb begin
    shadow_d = shadow_q;
    if (wr_i.en && (wr_i.offset < OffsetW'(ShadowWords))) begin
      shadow_d[wr_i.offset[ShadowAw-1:0]] = wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ShadowWords; k++) shadow_q[k] <= '0;
    end else if (wr_i.en) begin
      shadow_q <= shadow_d;
    end
  end

  for (genvar i = 0; i < RegionCount; i++) begin : g_lane
    logic [CmpW-1:0] lo;
    logic [CmpW-1:0] hi;
    logic [CmpW-1:0] pg;

    assign dec[i] = decode_region(version_i, shadow_d[SizeWord + i],
                                  shadow_d[BaseWord + i], shadow_d[Size3Word + i]);
    assign changed[i] = (dec[i] != region_q[i]);

    assign lo     = CmpW'(region_q[i].base);
    assign hi     = CmpW'(region_q[i].base) + CmpW'(region_q[i].size);
    assign pg     = CmpW'(page_i);
    assign hit[i] = (region_q[i].flags != '0) && (lo <= pg) && (pg < hi);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        region_q[i] <= '0;
      end else if (wr_i.en) begin
        region_q[i] <= dec[i];
      end
    end
  end

  assign changed_o = RegionsMax'(changed);
  assign hit_o     = |hit;

endmodule

[rtl/core/dma_region_access_checker_core.sv]
// Top level of the DMA region access checker: register window memory,
// transaction control and result register.
// Depends on dracc_pkg and dracc_regions.
//
// Usage. Transactions enter on the input channel (in_valid_i / in_stall_o)
// and one result leaves per transaction on the output channel
// (out_valid_o / out_stall_i). A write stores a word in the register window
// and reports which regions changed their decoded values. A read returns a
// stored word. A translate reports whether the page of the address lies in
// an enabled region, along with the page base address. The layout version
// is written through the cfg channel, which is always ready.
// Write, translate and unknown transactions go straight into the output
// register; a read first waits in the StRdWait state for the window memory.
// Without output stalls, a transaction is taken every cycle, except that a
// read holds the input while the block waits in the StRdWait state.
// After reset the block clears the 8192-word window memory, one word per
// cycle, and stalls the input until the clearing ends. A stalled result holds
// in the output register; a new transaction is taken only in a cycle where
// that register is empty or being drained.
module dma_region_access_checker_core import dracc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [1:0]             cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             operation_i,
  input  logic [OffsetW-1:0]     reg_offset_i,
  input  logic [DataW-1:0]       write_data_i,
  input  logic [AddressBits-1:0] dma_address_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [DataW-1:0]       read_data_o,
  output logic                   permitted_o,
  output logic [AddressBits-1:0] page_base_o,
  output logic [RegionsMax-1:0]  changed_regions_o
);

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StRdWait
  } state_e;

  state_e                 state_q;
  logic [MemAw-1:0]       clr_q;
  logic [1:0]             version_q;
  logic                   out_valid_q;
  logic [DataW-1:0]       read_data_q;
  logic                   permitted_q;
  logic [AddressBits-1:0] page_base_q;
  logic [RegionsMax-1:0]  changed_q;
  logic                   rd_oow_q;
  logic [DataW-1:0]       rd_data_q;
  logic [DataW-1:0]       mem [RegisterWords];

  op_e                    op;
  logic                   in_acc;
  logic                   in_window;
  reg_wr_t                wr;
  logic                   mem_we;
  logic [MemAw-1:0]       mem_waddr;
  logic [DataW-1:0]       mem_wdata;
  logic                   mem_re;
  logic [RegionsMax-1:0]  changed;
  logic                   hit;

  assign op         = op_e'(operation_i);
  assign in_stall_o = (state_q != StIdle) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_window  = {1'b0, reg_offset_i} < (OffsetW + 1)'(RegisterWords);

  assign wr.en     = in_acc && (op == OpWrite);
  assign wr.offset = reg_offset_i;
  assign wr.data   = write_data_i;

  assign mem_we    = (state_q == StClear) || (wr.en && in_window);
  assign mem_waddr = (state_q == StClear) ? clr_q : reg_offset_i[MemAw-1:0];
  assign mem_wdata = (state_q == StClear) ? '0 : write_data_i;
  assign mem_re    = in_acc && (op == OpRead);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[reg_offset_i[MemAw-1:0]];
    end
  end

  dracc_regions u_regions (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .version_i (version_q),
    .page_i    (dma_address_i[AddressBits-1:PageShift]),
    .changed_o (changed),
    .hit_o     (hit)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= Version1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      version_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      read_data_q <= '0;
      permitted_q <= 1'b0;
      page_base_q <= '0;
      changed_q   <= '0;
      rd_oow_q    <= 1'b0;
    end else begin
      unique case (state_q)
        StClear: begin
          clr_q <= clr_q + MemAw'(1);
          if (clr_q == MemAw'(RegisterWords - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_acc) begin
            read_data_q <= '0;
            permitted_q <= 1'b0;
            page_base_q <= '0;
            changed_q   <= '0;
            unique case (op)
              OpWrite: begin
                out_valid_q <= 1'b1;
                changed_q   <= changed;
              end
              OpRead: begin
                state_q  <= StRdWait;
                rd_oow_q <= !in_window;
              end
              OpXlate: begin
                out_valid_q <= 1'b1;
                permitted_q <= hit;
                page_base_q <= {dma_address_i[AddressBits-1:PageShift],
                                {PageShift{1'b0}}};
              end
              OpNone: begin
                out_valid_q <= 1'b1;
              end
            endcase
          end
        end
        StRdWait: begin
          out_valid_q <= 1'b1;
          read_data_q <= rd_oow_q ? '0 : rd_data_q;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign read_data_o       = read_data_q;
  assign permitted_o       = permitted_q;
  assign page_base_o       = page_base_q;
  assign changed_regions_o = changed_q;

  // A read enters the memory wait state and shows no result meanwhile.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OpRead)) |=> ((state_q == StRdWait) && !out_valid_q))
    else $error("read transaction did not enter the memory wait state");

  // A write produces its result on the next cycle with only the change mask set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OpWrite)) |=>
      (out_valid_o && (read_data_o == '0) && !permitted_o && (page_base_o == '0)))
    else $error("write result missing or carries stray fields");

  // No transaction is taken and no result is shown during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StClear) |-> (in_stall_o && !out_valid_o))
    else $error("activity during memory clearing pass");

  // A result never carries both a grant and a change mask.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(permitted_o && (changed_regions_o != '0)))
    else $error("result mixes translate and write fields");

endmodule

[verif/tb_dma_region_access_checker_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for dma_region_access_checker_core. It drives random and directed
// transactions and compares every result with a model of the register window and regions.
// Depends on dracc_pkg and the RTL of the block.
module tb_dma_region_access_checker_core;
  import dracc_pkg::*;

  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned IdleLimit  = 30000;
  localparam int unsigned LongHold   = 400;

  typedef struct packed {
    op_e                    op;
    logic [OffsetW-1:0]     offset;
    logic [DataW-1:0]       data;
    logic [AddressBits-1:0] addr;
  } access_t;

  typedef struct packed {
    logic [DataW-1:0]       read_data;
    logic                   permitted;
    logic [AddressBits-1:0] page_base;
    logic [RegionsMax-1:0]  changed;
  } response_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [1:0]             cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [1:0]             operation_i = '0;
  logic [OffsetW-1:0]     reg_offset_i = '0;
  logic [DataW-1:0]       write_data_i = '0;
  logic [AddressBits-1:0] dma_address_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [DataW-1:0]       read_data_o;
  logic                   permitted_o;
  logic [AddressBits-1:0] page_base_o;
  logic [RegionsMax-1:0]  changed_regions_o;

  logic [DataW-1:0]  win_words [RegisterWords];
  logic [FieldW-1:0] rgn_base  [RegionCount];
  logic [FieldW-1:0] rgn_size  [RegionCount];
  logic [DataW-1:0]  rgn_flags [RegionCount];
  logic [1:0]        layout_ver;

  access_t     access_queue[$];
  response_t   awaited_responses[$];
  access_t     cur_access;
  response_t   want_resp;
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned error_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_sender = 1'b0;
  bit          quiet_receiver = 1'b0;
  bit          hold_armed = 1'b0;
  bit          hold_spent = 1'b0;
  int unsigned phase_no;
  int unsigned pick;

  dma_region_access_checker_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .reg_offset_i      (reg_offset_i),
    .write_data_i      (write_data_i),
    .dma_address_i     (dma_address_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .read_data_o       (read_data_o),
    .permitted_o       (permitted_o),
    .page_base_o       (page_base_o),
    .changed_regions_o (changed_regions_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_error(input string msg);
    if (error_count < 40) $display("%0t ERROR %s", $realtime, msg);
    error_count++;
  endtask

  // Applies one accepted transaction to the window and region state and queues its result.
  task automatic resolve_access(input access_t a);
    response_t         r;
    logic [DataW-1:0]  w0;
    logic [DataW-1:0]  wb;
    logic [DataW-1:0]  ws;
    logic [FieldW-1:0] nb;
    logic [FieldW-1:0] ns;
    logic [DataW-1:0]  nf;
    logic [PageW-1:0]  page;
    logic [FieldW:0]   lim;
    r = '0;
    case (a.op)
      OpWrite: begin
        win_words[a.offset] = a.data;
        for (int i = 0; i < RegionCount; i++) begin
          w0 = win_words[SizeWord + i];
          wb = win_words[BaseWord + i];
          ws = win_words[Size3Word + i];
          if (layout_ver == Version3) begin
            nb = wb[29:0];
            ns = ws[29:0];
            nf = w0;
          end else if (layout_ver == Version2) begin
            nb = {6'b0, wb[23:0]};
            ns = {6'b0, w0[23:0]};
            nf = {20'b0, w0[11:0]};
          end else begin
            nb = {6'b0, wb[23:0]};
            ns = {11'b0, w0[18:0]};
            nf = {w0[31], 19'b0, w0[11:0]};
          end
          if (nb != rgn_base[i] || ns != rgn_size[i] || nf != rgn_flags[i]) begin
            r.changed[i] = 1'b1;
            rgn_base[i]  = nb;
            rgn_size[i]  = ns;
            rgn_flags[i] = nf;
          end
        end
      end
      OpRead: r.read_data = win_words[a.offset];
      OpXlate: begin
        page = a.addr[AddressBits-1:PageShift];
        r.page_base = {page, 12'h000};
        for (int i = 0; i < RegionCount; i++) begin
          lim = {1'b0, rgn_base[i]} + {1'b0, rgn_size[i]};
          if (rgn_flags[i] != '0 && {2'b0, rgn_base[i]} <= page && {1'b0, page} < lim)
            r.permitted = 1'b1;
        end
      end
      default: ;
    endcase
    awaited_responses.push_back(r);
  endtask

  task automatic push_access(input op_e op, input logic [OffsetW-1:0] off,
                             input logic [DataW-1:0] data, input logic [AddressBits-1:0] addr);
    access_t a;
    a.op     = op;
    a.offset = off;
    a.data   = data;
    a.addr   = addr;
    access_queue.push_back(a);
    issued_count++;
  endtask

  function automatic int unsigned pause_len(input bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [AddressBits-1:0] random_address();
    return AddressBits'({$urandom, $urandom});
  endfunction

  function automatic logic [OffsetW-1:0] random_offset();
    return OffsetW'($urandom);
  endfunction

  function automatic logic [OffsetW-1:0] layout_offset();
    return OffsetW'($urandom_range(0, Size3Word + RegionCount - 1));
  endfunction

  function automatic logic [DataW-1:0] shaped_word();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: return {1'b1, 23'b0, 8'($urandom)};
      3: return 32'hFFFF_FFFF;
      4: return 32'h0;
      default: return $urandom & 32'hFFFF_F000;
    endcase
  endfunction

  // Picks a page at, next to or inside the bounds of a region as currently decoded, or a random page.
  function automatic logic [AddressBits-1:0] aimed_address();
    int unsigned       k;
    logic [FieldW-1:0] b;
    logic [FieldW-1:0] s;
    logic [PageW-1:0]  page;
    k = $urandom_range(0, RegionCount - 1);
    b = rgn_base[k];
    s = rgn_size[k];
    case ($urandom_range(0, 5))
      0: page = PageW'(b - 1);
      1: page = b;
      2: page = PageW'(b + s - 1);
      3: page = PageW'(b + s);
      4: page = PageW'(b + ((s == 0) ? 0 : $urandom_range(0, s - 1)));
      default: page = PageW'($urandom);
    endcase
    return {page, 12'($urandom)};
  endfunction

  task automatic wait_idle();
    while (accepted_count != issued_count || awaited_responses.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_version(input logic [1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    layout_ver = v;
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        resolve_access(cur_access);
        accepted_count++;
        gap_left = pause_len(quiet_sender);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (access_queue.size() != 0) begin
          cur_access = access_queue.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= cur_access.op;
          reg_offset_i  <= cur_access.offset;
          write_data_i  <= cur_access.data;
          dma_address_i <= cur_access.addr;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_responses.size() == 0) begin
          report_error("result arrived with no transaction outstanding");
        end else begin
          want_resp = awaited_responses.pop_front();
          if (read_data_o !== want_resp.read_data)
            report_error($sformatf("read_data %h, expected %h", read_data_o,
                                   want_resp.read_data));
          if (permitted_o !== want_resp.permitted)
            report_error($sformatf("permitted %b, expected %b", permitted_o,
                                   want_resp.permitted));
          if (page_base_o !== want_resp.page_base)
            report_error($sformatf("page_base %h, expected %h", page_base_o,
                                   want_resp.page_base));
          if (changed_regions_o !== want_resp.changed)
            report_error($sformatf("changed_regions %h, expected %h", changed_regions_o,
                                   want_resp.changed));
        end
        stall_left = pause_len(quiet_receiver);
      end
      if (hold_armed && !hold_spent) begin
        hold_spent = 1'b1;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (win_words[k]) win_words[k] = '0;
    foreach (rgn_base[k]) begin
      rgn_base[k]  = '0;
      rgn_size[k]  = '0;
      rgn_flags[k] = '0;
    end
    layout_ver = Version1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_version(Version1);

    // Empty state, a small region and the largest narrow base.
    push_access(OpRead, '0, $urandom, random_address());
    push_access(OpXlate, random_offset(), $urandom, '0);
    push_access(OpWrite, OffsetW'(SizeWord), 32'h8000_0010, random_address());
    push_access(OpWrite, OffsetW'(BaseWord), 32'h0000_0005, random_address());
    push_access(OpXlate, random_offset(), $urandom, {30'd4, 12'hFFF});
    push_access(OpXlate, random_offset(), $urandom, {30'd5, 12'h000});
    push_access(OpXlate, random_offset(), $urandom, {30'h14, 12'h123});
    push_access(OpXlate, random_offset(), $urandom, {30'h15, 12'h000});
    push_access(OpWrite, OffsetW'(BaseWord + 15), 32'hFFFF_FFFF, '0);
    push_access(OpWrite, OffsetW'(SizeWord + 15), 32'hFFFF_FFFF, '0);
    push_access(OpXlate, '1, '1, {30'hFF_FFFF, 12'h000});
    push_access(OpXlate, '0, '0, '1);
    push_access(OpWrite, '1, 32'hFFFF_FFFF, '1);
    push_access(OpRead, '1, '0, '0);
    push_access(OpRead, OffsetW'(SizeWord + 15), '1, '1);
    push_access(OpNone, '1, '1, '1);
    push_access(OpWrite, OffsetW'(Size3Word), 32'h3FFF_FFFF, '0);
    wait_idle();
    // The new layout takes effect only at the next register write.
    write_version(Version3);
    push_access(OpXlate, '0, '0, {30'd5, 12'h000});
    push_access(OpWrite, 13'd100, 32'h0, '0);
    push_access(OpXlate, '0, '0, '1);
    push_access(OpXlate, '0, '0, {30'd4, 12'hFFF});
    wait_idle();
    write_version(2'd0);
    push_access(OpWrite, OffsetW'(SizeWord), 32'h0000_1000, '0);
    push_access(OpXlate, '0, '0, {30'd5, 12'h000});
    wait_idle();

    phase_no = 0;
    while (issued_count < ItemTarget) begin
      case (phase_no % 6)
        0: write_version(Version2);
        1: write_version(Version3);
        2: write_version(Version1);
        3: write_version(2'd0);
        4: write_version(Version3);
        default: write_version(Version2);
      endcase
      quiet_sender   = ($urandom_range(0, 3) == 0);
      quiet_receiver = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(8, 16))
        push_access(OpWrite, layout_offset(), shaped_word(), random_address());
      wait_idle();
      if (phase_no == 2) begin
        quiet_sender = 1'b1;
        hold_armed   = 1'b1;
      end
      repeat (150) begin
        pick = $urandom_range(0, 99);
        if (pick < 50)
          push_access(OpXlate, random_offset(), $urandom, aimed_address());
        else if (pick < 60)
          push_access(OpXlate, random_offset(), $urandom, random_address());
        else if (pick < 72)
          push_access(OpWrite, layout_offset(), shaped_word(), random_address());
        else if (pick < 78)
          push_access(OpWrite, random_offset(), $urandom, random_address());
        else if (pick < 86)
          push_access(OpRead, layout_offset(), $urandom, random_address());
        else if (pick < 93)
          push_access(OpRead, random_offset(), $urandom, random_address());
        else
          push_access(OpNone, random_offset(), $urandom, random_address());
      end
      wait_idle();
      phase_no++;
    end

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/dracc_pkg.sv
rtl/core/dracc_regions.sv
rtl/core/dma_region_access_checker_core.sv
verif/tb_dma_region_access_checker_core.sv
